// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the framer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AST_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AST_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/dlf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlf_pkg
// Types and constants shared by the delimiter/length framer and its cells.
// ----------------------------------------------------------------------------
package dlf_pkg;

  localparam int unsigned MAX_DELIM_BYTES_DEF = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DLEN_W  = 4;
  localparam int unsigned DELIM_W = 64;
  localparam int unsigned FLEN_W  = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned BSEL_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic                 RST_FRAME_MODE = 1'b0;
  localparam logic [DLEN_W-1:0]    RST_DELIM_LEN  = 4'd2;
  localparam logic [DELIM_W-1:0]   RST_DELIM      = 64'h0000_0000_0000_0A0D;
  localparam logic [FLEN_W-1:0]    RST_FRAME_LEN  = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_MODE  = 2'd0,
    REG_DELIM_LEN   = 2'd1,
    REG_DELIM_BYTES = 2'd2,
    REG_FRAME_LEN   = 2'd3
  } cfg_reg_t;

  // Control handed from the top level to every cell of the shift chain.
  typedef struct packed {
    logic              advance;  // a byte of an enabled request moves in
    logic              flush;    // that byte closes the frame
    logic [DLEN_W-1:0] dlen;     // delimiter length in use, already clamped
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/dlf_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlf_cell
// One byte slot of the recent-byte chain: holds a byte and its in-frame bit,
// compares the incoming byte with its delimiter byte.
// ----------------------------------------------------------------------------
module dlf_cell import dlf_pkg::*; #(
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  logic [DELIM_W-1:0] delim,
  input  logic [BYTE_W-1:0]  shift_byte,
  input  logic               shift_valid,
  output logic [BYTE_W-1:0]  cell_byte,
  output logic               cell_valid,
  output logic               hit
);

  localparam logic [DLEN_W-1:0] POS = DLEN_W'(CELL_INDEX);

  logic [DLEN_W-1:0] want_idx;
  logic [BYTE_W-1:0] want;
  logic              in_use;

  // Slot POS is compared with delimiter byte (dlen - 1 - POS).
  always_comb begin
    want_idx = ctrl.dlen - POS - DLEN_W'(1);
    want     = delim[BYTE_W*want_idx[BSEL_W-1:0] +: BYTE_W];
    in_use   = POS < ctrl.dlen;
    hit      = !in_use || (shift_valid && (shift_byte == want));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (ctrl.advance) begin
      cell_valid <= shift_valid && !ctrl.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      cell_byte <= shift_byte;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/delimiter_or_length_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// delimiter_or_length_framer
// Cuts a byte stream into frames by delimiter match or by fixed byte count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one stream byte per request.
//   Output channel out_valid/out_ready returns the same byte with frame_last
//   set on the byte that completes the delimiter (mode 0) or reaches
//   frame_length bytes (mode 1).
//   The output is registered: an accepted byte is shown on out_byte in the
//   cycle after it is taken. Throughput is one byte per cycle, set by the
//   single output register, unless the receiver stalls; the delimiter compare
//   spans a byte cell per possible delimiter byte, shifting per enabled byte.
//   With a zero delimiter length (mode 0) or zero frame_length (mode 1) an
//   accepted byte is dropped: no output, frame state untouched.
//   A stalled receiver holds the output register; in_ready then falls, so
//   no request is taken until the held result leaves.
//   Reset (synchronous, rst high) empties the frame, clears the output and
//   loads the default configuration: delimiter mode, CR LF delimiter.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
module delimiter_or_length_framer import dlf_pkg::*; #(
  parameter int unsigned MAX_DELIMITER_BYTES = MAX_DELIM_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELIM_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 frame_last
);

  `include "assert_macros.svh"

  localparam int unsigned NCELL = MAX_DELIMITER_BYTES;
  localparam logic [DLEN_W-1:0] MAX_DLEN = DLEN_W'(MAX_DELIMITER_BYTES);

  // Configuration registers
  logic                frame_mode;
  logic [DLEN_W-1:0]   delimiter_length;
  logic [DELIM_W-1:0]  delim_pattern;
  logic [FLEN_W-1:0]   frame_length;

  // Frame state
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_inc;

  logic [DLEN_W-1:0]   eff_len;
  logic                enabled;
  logic                accept;
  logic                delim_hit;
  logic                last;
  cell_ctrl_t          ctrl;

  logic [BYTE_W-1:0]   cell_byte  [NCELL];
  logic                cell_valid [NCELL];
  logic [NCELL-1:0]    hit;

  // Configuration writes: take the register addressed by cfg_index.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode       <= RST_FRAME_MODE;
      delimiter_length <= RST_DELIM_LEN;
      delim_pattern    <= RST_DELIM;
      frame_length     <= RST_FRAME_LEN;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_MODE:  frame_mode       <= cfg_data[0];
        REG_DELIM_LEN:   delimiter_length <= cfg_data[DLEN_W-1:0];
        REG_DELIM_BYTES: delim_pattern    <= cfg_data;
        REG_FRAME_LEN:   frame_length     <= cfg_data[FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept whenever the output register is empty or being drained.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    eff_len   = (delimiter_length > MAX_DLEN) ? MAX_DLEN : delimiter_length;
    enabled   = frame_mode ? (frame_length != '0) : (delimiter_length != '0);
    count_inc = (count == {CNT_W{1'b1}}) ? count : count + CNT_W'(1);
    delim_hit = &hit;
    last      = frame_mode ? (count_inc >= frame_length) : delim_hit;
    ctrl.advance = accept && enabled;
    ctrl.flush   = accept && enabled && last;
    ctrl.dlen    = eff_len;
  end

  // Chain of byte cells: cell 0 takes the new byte, each later cell takes
  // its left neighbour's byte. A cell's in-frame bit stands in for the
  // "enough bytes in this frame" test of the delimiter match.
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    logic [BYTE_W-1:0] src_byte;
    logic              src_valid;
    if (j == 0) begin : g_head
      assign src_byte  = in_byte;
      assign src_valid = 1'b1;
    end else begin : g_link
      assign src_byte  = cell_byte[j-1];
      assign src_valid = cell_valid[j-1];
    end
    dlf_cell #(
      .CELL_INDEX (j)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .delim       (delim_pattern),
      .shift_byte  (src_byte),
      .shift_valid (src_valid),
      .cell_byte   (cell_byte[j]),
      .cell_valid  (cell_valid[j]),
      .hit         (hit[j])
    );
  end

  // Frame byte counter: advance with saturation, drop to zero at frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.advance) begin
      count <= last ? '0 : count_inc;
    end
  end

  // Output register: hold while stalled, load on an enabled request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      out_byte   <= in_byte;
      frame_last <= last;
    end
  end

  `AST_NEXT(a_flush_clears, clk, rst, ctrl.flush, (count == '0) && !cell_valid[0])
  `AST_NOW(a_empty_frame, clk, rst, count == '0, !cell_valid[0])
  `AST_NOW(a_delim_len_ok, clk, rst, ctrl.flush && !frame_mode, count_inc >= CNT_W'(eff_len))
  `AST_NEXT(a_drop_silent, clk, rst, accept && !enabled && !out_valid, !out_valid)

endmodule
`default_nettype wire

// ===== test/tb_delimiter_or_length_framer.sv =====
// ----------------------------------------------------------------------------
// tb_delimiter_or_length_framer
// Self-checking bench for the byte-stream framer. Every accepted request is fed
// to a behavioural copy of the framer, which queues the byte and end-of-frame
// flag due out. Each output handshake is checked against the oldest queued
// entry. Directed bytes cover the corner cases. Randomised phases follow, each
// with fresh settings. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_delimiter_or_length_framer;
  import dlf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } framed_byte_t;

  // Behavioural framer: holds its own copy of the settings and frame state,
  // and the bytes that the block still owes on its output.
  class frame_cutter;
    logic               mode;
    logic [DLEN_W-1:0]  dlen;
    logic [DELIM_W-1:0] delim;
    logic [FLEN_W-1:0]  flen;
    logic [DELIM_W-1:0] recent;
    logic [CNT_W-1:0]   fill;
    framed_byte_t       bytes_due[$];
    int unsigned        errors;

    function new();
      mode   = RST_FRAME_MODE;
      dlen   = RST_DELIM_LEN;
      delim  = RST_DELIM;
      flen   = RST_FRAME_LEN;
      recent = '0;
      fill   = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [DELIM_W-1:0] data);
      case (idx)
        REG_FRAME_MODE:  mode  = data[0];
        REG_DELIM_LEN:   dlen  = data[DLEN_W-1:0];
        REG_DELIM_BYTES: delim = data;
        REG_FRAME_LEN:   flen  = data[FLEN_W-1:0];
        default: ;
      endcase
    endfunction

    // The newest byte sits in the low lane, so the delimiter runs backwards.
    function bit delim_seen(int unsigned span);
      int unsigned i;
      if (fill < span) return 1'b0;
      for (i = 0; i < span; i++)
        if (delim[8*i +: 8] != recent[8*(span-1-i) +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    // Note an accepted request; return 1 when it is owed on the output.
    function bit take_byte(logic [BYTE_W-1:0] b);
      int unsigned  span;
      logic         ends;
      framed_byte_t item;
      span = 0;
      if (mode == 1'b0) begin
        if (dlen == 0) return 1'b0;
        span = (dlen > MAX_DELIM_BYTES_DEF) ? MAX_DELIM_BYTES_DEF : dlen;
      end else if (flen == 0) begin
        return 1'b0;
      end
      recent = {recent[DELIM_W-9:0], b};
      if (fill != '1) fill++;
      ends = (mode == 1'b0) ? delim_seen(span) : (fill >= flen);
      item.data = b;
      item.last = ends;
      bytes_due = {bytes_due, item};
      if (ends) begin
        recent = '0;
        fill   = '0;
      end
      return 1'b1;
    endfunction

    function void match_output(logic [BYTE_W-1:0] b, logic last);
      framed_byte_t exp;
      if (bytes_due.size() == 0) begin
        $error("unexpected output: out_byte %02h frame_last %0b", b, last);
        errors++;
        return;
      end
      exp = bytes_due.pop_front();
      if (b !== exp.data) begin
        $error("out_byte: expected %02h, got %02h", exp.data, b);
        errors++;
      end
      if (last !== exp.last) begin
        $error("frame_last: expected %0b, got %0b", exp.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_MODE;
  logic [DELIM_W-1:0]   cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_byte   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 frame_last;

  frame_cutter sb = new();

  int unsigned enabled_bytes = 0;  // requests that owe an output byte
  int unsigned hold_asks     = 0;  // bumped to make the receiver hold off
  bit          tx_calm       = 1'b0;

  delimiter_or_length_framer u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .frame_last (frame_last)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block wedges.
  initial begin
    #100_000_000;
    $display("[delimiter_or_length_framer] ERROR");
    $finish;
  end

  // Write one register, then drop the enable before the task returns so that
  // back-to-back writes never raise and lower it in the same step.
  task automatic write_reg(cfg_reg_t idx, logic [DELIM_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic mode, logic [DLEN_W-1:0] dlen,
                           logic [DELIM_W-1:0] delim, logic [FLEN_W-1:0] flen);
    write_reg(REG_FRAME_MODE, DELIM_W'(mode));
    write_reg(REG_DELIM_LEN, DELIM_W'(dlen));
    write_reg(REG_DELIM_BYTES, delim);
    write_reg(REG_FRAME_LEN, DELIM_W'(flen));
  endtask

  // Offer one request, after a random gap unless the sender is in a calm
  // stretch, and hold it until the block takes it.
  task automatic send_byte(logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 2);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    if (sb.take_byte(b)) enabled_bytes++;
  endtask

  // Drain: stop offering, wait for every owed byte, then allow the
  // registered output to settle in case the last request was dropped.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed traffic: whole delimiters, broken prefixes of one,
  // loose delimiter bytes and plain noise.
  task automatic send_stream(int unsigned n_bytes);
    int unsigned sent, k, span, pick, cut;
    span = (sb.dlen == 0) ? 1 : ((sb.dlen > MAX_DELIM_BYTES_DEF) ? MAX_DELIM_BYTES_DEF : sb.dlen);
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        cut = (pick == 3 && span > 1) ? $urandom_range(1, span - 1) : span;
        for (k = 0; k < cut; k++) send_byte(sb.delim[8*k +: 8]);
        sent += cut;
      end else begin
        k = $urandom_range(0, 7);
        send_byte((pick <= 6) ? sb.delim[8*k +: 8] : BYTE_W'($urandom));
        sent++;
      end
    end
  endtask

  // Receiver: check every output handshake, then pick the next ready level.
  // Stalls are mostly short, now and then long, with calm stretches between.
  initial begin : receiver
    int unsigned stall_left, calm_left, pick, holds_done;
    stall_left = 0;
    calm_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.match_output(out_byte, frame_last);
      if (hold_asks != holds_done) begin
        // Hold off long enough for the block to fill and stall its input.
        holds_done++;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (calm_left > 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          calm_left = $urandom_range(20, 200);
          out_ready <= 1'b1;
        end else if (pick <= 5) begin
          stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned phase, r;
    logic               mode;
    logic [DLEN_W-1:0]  dlen;
    logic [DELIM_W-1:0] delim;
    logic [FLEN_W-1:0]  flen;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, CR LF delimiter: a plain match, a lone LF that is
    // too short to match, the byte extremes, then a second CR LF pair.
    send_byte(8'h0D);
    send_byte(8'h0A);
    send_byte(8'h0A);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h0D);
    send_byte(8'h0A);
    wait_idle();

    // All-zero delimiter: the first zero must not match on an empty frame.
    write_reg(REG_DELIM_BYTES, '0);
    send_byte(8'h00);
    send_byte(8'h00);
    wait_idle();

    // Zero delimiter length: drop every byte.
    write_reg(REG_DELIM_LEN, '0);
    send_byte(8'h5A);
    send_byte(8'hA5);
    wait_idle();

    // Over-long delimiter length clamps to eight bytes.
    configure(1'b0, '1, '1, '0);
    repeat (8) send_byte(8'hFF);
    wait_idle();

    // Length mode: zero length drops, then one-byte frames.
    write_reg(REG_FRAME_MODE, DELIM_W'(1));
    send_byte(8'h11);
    wait_idle();
    write_reg(REG_FRAME_LEN, DELIM_W'(1));
    send_byte(8'h80);
    wait_idle();

    // Lower the length mid-frame: the next byte closes the frame.
    write_reg(REG_FRAME_LEN, DELIM_W'(3));
    send_byte(8'h01);
    send_byte(8'h02);
    wait_idle();
    write_reg(REG_FRAME_LEN, DELIM_W'(1));
    send_byte(8'h03);
    wait_idle();

    // Switch mode mid-frame: the open frame carries on under the delimiter.
    write_reg(REG_FRAME_LEN, DELIM_W'(5));
    send_byte(8'h21);
    send_byte(8'h42);
    wait_idle();
    configure(1'b0, 4'd1, DELIM_W'(8'h42), 16'd5);
    send_byte(8'h42);
    wait_idle();

    // Random phases, fresh settings each time; the open frame is carried over.
    enabled_bytes = 0;
    phase = 0;
    while (enabled_bytes < 1450) begin
      mode = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 19);
      if (r == 0)       dlen = '0;
      else if (r <= 16) dlen = DLEN_W'((r - 1) % 8 + 1);
      else              dlen = DLEN_W'($urandom_range(9, 15));
      delim = {$urandom, $urandom};
      if ($urandom_range(0, 2) == 0)
        for (r = 0; r < 8; r++) delim[8*r +: 8] = $urandom_range(0, 1) ? 8'h0D : 8'h0A;
      r = $urandom_range(0, 11);
      if (r == 0)      flen = '0;
      else if (r <= 9) flen = FLEN_W'($urandom_range(1, 16));
      else             flen = FLEN_W'($urandom_range(17, 200));
      tx_calm = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // Keep offering while the receiver holds off.
        mode = 1'b1;
        flen = FLEN_W'($urandom_range(1, 16));
        tx_calm = 1'b1;
        hold_asks <= hold_asks + 1;
      end
      configure(mode, dlen, delim, flen);
      send_stream($urandom_range(40, 160));
      wait_idle();
      phase++;
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.bytes_due.size() == 0) begin
      $display("[delimiter_or_length_framer] OK");
    end else begin
      $display("[delimiter_or_length_framer] ERROR");
    end
    $finish;
  end

endmodule
